// ----- rtl/cts_pkg.sv -----
// shared types, constants and fixed-point helpers for the cyclic tridiagonal solver
package cts_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS = 16;
  localparam int IDX_W = 6;
  localparam int QUO_W = DATA_WIDTH + FRAC_BITS;
  localparam int DCNT_W = $clog2(QUO_W + 1);
  localparam int ADDR_W = 3;

  localparam logic [ADDR_W-1:0] ADDR_HALF_INV_DX = 3'd0;
  localparam logic [DATA_WIDTH-1:0] HALF_INV_DX_RESET = 32'h0001_0000;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_ZERO_PIVOT = 2'd1;
  localparam logic [1:0] STATUS_SHORT = 2'd2;
  localparam logic [1:0] STATUS_SATURATED = 2'd3;

  localparam logic [DATA_WIDTH-1:0] VAL_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] VAL_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] diag_coeff;
    logic signed [DATA_WIDTH-1:0] coupling_coeff;
    logic signed [DATA_WIDTH-1:0] rhs_value;
    logic last_row;
  } request_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] solution_value;
    logic [IDX_W-1:0] row_index;
    logic last_result;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    logic ovf;
    logic [DATA_WIDTH-1:0] val;
  } sat_t;

  function automatic sat_t sat_add(logic [DATA_WIDTH-1:0] a, logic [DATA_WIDTH-1:0] b);
    logic [DATA_WIDTH:0] s;
    sat_t r;
    s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
    r.ovf = s[DATA_WIDTH] != s[DATA_WIDTH-1];
    r.val = r.ovf ? (s[DATA_WIDTH] ? VAL_MIN : VAL_MAX) : s[DATA_WIDTH-1:0];
    return r;
  endfunction

  function automatic sat_t sat_sub(logic [DATA_WIDTH-1:0] a, logic [DATA_WIDTH-1:0] b);
    logic [DATA_WIDTH:0] s;
    sat_t r;
    s = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
    r.ovf = s[DATA_WIDTH] != s[DATA_WIDTH-1];
    r.val = r.ovf ? (s[DATA_WIDTH] ? VAL_MIN : VAL_MAX) : s[DATA_WIDTH-1:0];
    return r;
  endfunction

  function automatic sat_t sat_mul(logic [DATA_WIDTH-1:0] a, logic [DATA_WIDTH-1:0] b);
    logic signed [2*DATA_WIDTH-1:0] p;
    logic signed [2*DATA_WIDTH-1:0] bias;
    logic signed [2*DATA_WIDTH-1:0] pt;
    logic [DATA_WIDTH:0] top;
    sat_t r;
    p = $signed({{DATA_WIDTH{a[DATA_WIDTH-1]}}, a}) * $signed({{DATA_WIDTH{b[DATA_WIDTH-1]}}, b});
    bias = p[2*DATA_WIDTH-1] ? $signed({{(2*DATA_WIDTH-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}})
                             : '0;
    pt = (p + bias) >>> FRAC_BITS;
    top = pt[2*DATA_WIDTH-1:DATA_WIDTH-1];
    r.ovf = !((&top) || (~|top));
    r.val = r.ovf ? (pt[2*DATA_WIDTH-1] ? VAL_MIN : VAL_MAX) : pt[DATA_WIDTH-1:0];
    return r;
  endfunction

endpackage

// ----- rtl/cyclic_tridiagonal_solver.sv -----
// cyclic tridiagonal solver: row memories, elimination sequencer and serial divider
//
// rows come in on request when start is high and busy is low, one row per request;
// busy stays low while rows load, one row per cycle. the row with last_row set, or
// the row that fills MAX_ROWS, starts the solve and raises busy.
// the solve keeps rows, elimination terms and solutions in on-chip memories with a
// registered read and runs one shared multiplier and one radix-2 divider of 48 steps.
// each of the first n-1 rows takes three divides; the last-row reduction and the back
// substitution then run row by row, and the n solutions leave in row order.
// fewer than three rows skip the solve and return zeros with status short.
// each solution is on result for one cycle with result_valid high; the receiver
// cannot stall it. busy falls with the last solution.
// the user writes half_inv_dx over the apb port only while the block is idle; the block itself does not enforce it.
// rst clears the sequencer, row count, flags and half_inv_dx to 1.0; the memories
// keep their contents.
module cyclic_tridiagonal_solver import cts_pkg::*; #(
  parameter int MAX_ROWS = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  request_t request,
  output logic result_valid,
  output result_t result,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_WIDTH-1:0] pwdata,
  output logic [DATA_WIDTH-1:0] prdata,
  output logic pready
);

  localparam int AW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_ROWS + 1);
  localparam int W = DATA_WIDTH;

  localparam logic [5:0] S_IDLE = 6'd0;
  localparam logic [5:0] S_F0 = 6'd1;
  localparam logic [5:0] S_F1 = 6'd2;
  localparam logic [5:0] S_F2 = 6'd3;
  localparam logic [5:0] S_F3 = 6'd4;
  localparam logic [5:0] S_F4 = 6'd5;
  localparam logic [5:0] S_F5 = 6'd6;
  localparam logic [5:0] S_F6 = 6'd7;
  localparam logic [5:0] S_F7 = 6'd8;
  localparam logic [5:0] S_F8 = 6'd9;
  localparam logic [5:0] S_F9 = 6'd10;
  localparam logic [5:0] S_R0 = 6'd11;
  localparam logic [5:0] S_R1 = 6'd12;
  localparam logic [5:0] S_R2 = 6'd13;
  localparam logic [5:0] S_R3 = 6'd14;
  localparam logic [5:0] S_R4 = 6'd15;
  localparam logic [5:0] S_R5 = 6'd16;
  localparam logic [5:0] S_R6 = 6'd17;
  localparam logic [5:0] S_R7 = 6'd18;
  localparam logic [5:0] S_R8 = 6'd19;
  localparam logic [5:0] S_R9 = 6'd20;
  localparam logic [5:0] S_R10 = 6'd21;
  localparam logic [5:0] S_R11 = 6'd22;
  localparam logic [5:0] S_R12 = 6'd23;
  localparam logic [5:0] S_B0 = 6'd24;
  localparam logic [5:0] S_B1 = 6'd25;
  localparam logic [5:0] S_B2 = 6'd26;
  localparam logic [5:0] S_B3 = 6'd27;
  localparam logic [5:0] S_B4 = 6'd28;
  localparam logic [5:0] S_O0 = 6'd29;
  localparam logic [5:0] S_O1 = 6'd30;
  localparam logic [5:0] S_O2 = 6'd31;

  logic [W-1:0] diag_mem [MAX_ROWS];
  logic [W-1:0] coup_mem [MAX_ROWS];
  logic [W-1:0] rhs_mem [MAX_ROWS];
  logic [W-1:0] eu_mem [MAX_ROWS];
  logic [W-1:0] ec_mem [MAX_ROWS];
  logic [W-1:0] eo_mem [MAX_ROWS];
  logic [W-1:0] sol_mem [MAX_ROWS];
  logic [W-1:0] rd_d, rd_s, rd_r, rd_eu, rd_ec, rd_eo, rd_sol;

  logic [5:0] state;
  logic [CW-1:0] row_count;
  logic [AW-1:0] k, last, rd_addr;
  logic first, short_run, flag_sat, flag_zero;
  logic [1:0] status;
  logic [W-1:0] half_inv_dx;
  logic [W-1:0] dv, rv, pv, qv, ll, lv, uv, den, cur_eu, cur_ec;
  logic [W-1:0] p_eu, p_ec, p_eo, e_u, e_c, e_o, tv, sv, xl, xn, acc;

  logic mul_en;
  logic [W-1:0] mul_a, mul_b, mres;
  sat_t mul_out;

  logic div_start, div_run, div_done, div_neg;
  logic [W-1:0] div_a, div_b, div_nb, div_q;
  logic [W:0] div_rem, rem_sh, rem_nx;
  logic [QUO_W-1:0] div_quo, quo_nx;
  logic [DCNT_W-1:0] div_cnt;
  logic q_bit, q_ovf;
  logic [W-1:0] q_val;

  logic accept, fill, cfg_wr;
  sat_t a_u, a_den, a_num, a_pv, a_rv, a_qv, a_t, a_s, a_den2, a_num2, a_acc, a_x;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_HALF_INV_DX) ? half_inv_dx : '0;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign busy = state != S_IDLE;
  assign accept = start && !busy;
  assign fill = row_count == CW'(MAX_ROWS - 1);

  always_comb begin
    case (state)
      S_R0: rd_addr = last;
      S_R3: rd_addr = k - AW'(1);
      default: rd_addr = k;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      diag_mem[row_count[AW-1:0]] <= request.diag_coeff;
      coup_mem[row_count[AW-1:0]] <= request.coupling_coeff;
      rhs_mem[row_count[AW-1:0]] <= request.rhs_value;
    end
    if (state == S_F9 && div_done) begin
      eu_mem[k] <= cur_eu;
      ec_mem[k] <= cur_ec;
      eo_mem[k] <= div_q;
    end
    if (state == S_R12 && div_done) begin
      sol_mem[last] <= div_q;
    end
    if (state == S_B4) begin
      sol_mem[k] <= a_x.val;
    end
    rd_d <= diag_mem[rd_addr];
    rd_s <= coup_mem[rd_addr];
    rd_r <= rhs_mem[rd_addr];
    rd_eu <= eu_mem[rd_addr];
    rd_ec <= ec_mem[rd_addr];
    rd_eo <= eo_mem[rd_addr];
    rd_sol <= sol_mem[rd_addr];
  end

  // shared multiplier operand select
  always_comb begin
    mul_en = 1'b0;
    mul_a = half_inv_dx;
    mul_b = rd_s;
    case (state)
      S_F1, S_R1: begin
        mul_en = 1'b1;
      end
      S_F2: begin
        mul_en = !first;
        mul_a = mres;
        mul_b = p_eu;
      end
      S_F5: begin
        mul_en = !first && div_done;
        mul_a = lv;
        mul_b = p_ec;
      end
      S_F7: begin
        mul_en = !first && div_done;
        mul_a = lv;
        mul_b = p_eo;
      end
      S_R4: begin
        mul_en = 1'b1;
        mul_a = qv;
        mul_b = rd_ec;
      end
      S_R5: begin
        mul_en = 1'b1;
        mul_a = qv;
        mul_b = e_o;
      end
      S_R6: begin
        mul_en = 1'b1;
        mul_a = qv;
        mul_b = e_u;
      end
      S_R9: begin
        mul_en = 1'b1;
        mul_a = tv;
        mul_b = sv;
      end
      S_R10: begin
        mul_en = 1'b1;
        mul_a = tv;
        mul_b = p_eo;
      end
      S_B1: begin
        mul_en = 1'b1;
        mul_a = rd_eu;
        mul_b = xn;
      end
      S_B2: begin
        mul_en = 1'b1;
        mul_a = e_c;
        mul_b = xl;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  assign mul_out = sat_mul(mul_a, mul_b);

  assign a_u = sat_sub('0, mres);
  assign a_den = sat_sub(dv, mres);
  assign a_num = sat_add(rv, mres);
  assign a_pv = sat_sub(pv, mres);
  assign a_rv = sat_add(rv, mres);
  assign a_qv = sat_sub('0, mres);
  assign a_t = sat_add(qv, ll);
  assign a_s = sat_add(p_eu, p_ec);
  assign a_den2 = sat_sub(pv, mres);
  assign a_num2 = sat_add(rv, mres);
  assign a_acc = sat_add(acc, mres);
  assign a_x = sat_add(acc, e_o);

  // divider operand select
  always_comb begin
    div_start = 1'b0;
    div_a = uv;
    div_b = den;
    case (state)
      S_F4: begin
        div_start = 1'b1;
      end
      S_F6: begin
        div_start = 1'b1;
        div_a = first ? lv : mres;
      end
      S_F8: begin
        div_start = 1'b1;
        div_a = first ? rv : a_num.val;
      end
      S_R11: begin
        div_start = 1'b1;
        div_a = a_num2.val;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // restoring divider, one quotient bit per cycle
  assign rem_sh = {div_rem[W-1:0], div_quo[QUO_W-1]};
  assign q_bit = rem_sh >= {1'b0, div_nb};
  assign rem_nx = q_bit ? rem_sh - {1'b0, div_nb} : rem_sh;
  assign quo_nx = {div_quo[QUO_W-2:0], q_bit};

  always_comb begin
    if (!div_neg) begin
      q_ovf = |quo_nx[QUO_W-1:W-1];
      q_val = q_ovf ? VAL_MAX : quo_nx[W-1:0];
    end else begin
      q_ovf = (|quo_nx[QUO_W-1:W]) || (quo_nx[W-1] && (|quo_nx[W-2:0]));
      q_val = q_ovf ? VAL_MIN : W'(-quo_nx[W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_run <= 1'b0;
      div_done <= 1'b0;
      div_cnt <= '0;
    end else begin
      div_done <= 1'b0;
      if (div_start) begin
        div_neg <= div_a[W-1] ^ div_b[W-1];
        div_nb <= div_b[W-1] ? W'(-div_b) : div_b;
        div_quo <= {(div_a[W-1] ? W'(-div_a) : div_a), {FRAC_BITS{1'b0}}};
        div_rem <= '0;
        div_cnt <= DCNT_W'(QUO_W);
        if (div_b == '0) begin
          div_done <= 1'b1;
          div_q <= '0;
        end else begin
          div_run <= 1'b1;
        end
      end else if (div_run) begin
        div_rem <= rem_nx;
        div_quo <= quo_nx;
        div_cnt <= div_cnt - DCNT_W'(1);
        if (div_cnt == DCNT_W'(1)) begin
          div_run <= 1'b0;
          div_done <= 1'b1;
          div_q <= q_val;
        end
      end
    end
  end

  // flags
  always_ff @(posedge clk) begin
    if (rst || (accept && (request.last_row || fill))) begin
      flag_sat <= 1'b0;
      flag_zero <= 1'b0;
    end else begin
      if (mul_en && mul_out.ovf) flag_sat <= 1'b1;
      if (div_run && div_cnt == DCNT_W'(1) && q_ovf) flag_sat <= 1'b1;
      if (div_start && div_b == '0) flag_zero <= 1'b1;
      case (state)
        S_F2: if (a_u.ovf) flag_sat <= 1'b1;
        S_F3: if (a_den.ovf) flag_sat <= 1'b1;
        S_F8: if (!first && a_num.ovf) flag_sat <= 1'b1;
        S_R2: if (a_qv.ovf) flag_sat <= 1'b1;
        S_R5: if (a_pv.ovf) flag_sat <= 1'b1;
        S_R6: if (a_rv.ovf) flag_sat <= 1'b1;
        S_R8: if (a_t.ovf || a_s.ovf) flag_sat <= 1'b1;
        S_R10: if (a_den2.ovf) flag_sat <= 1'b1;
        S_R11: if (a_num2.ovf) flag_sat <= 1'b1;
        S_B3: if (a_acc.ovf) flag_sat <= 1'b1;
        S_B4: if (a_x.ovf) flag_sat <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_inv_dx <= HALF_INV_DX_RESET;
    end else if (cfg_wr && paddr == ADDR_HALF_INV_DX) begin
      half_inv_dx <= pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) mres <= mul_out.val;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      row_count <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (request.last_row || fill) begin
              row_count <= '0;
              last <= row_count[AW-1:0];
              k <= '0;
              first <= 1'b1;
              short_run <= row_count < CW'(2);
              state <= (row_count < CW'(2)) ? S_O0 : S_F0;
            end else begin
              row_count <= row_count + CW'(1);
            end
          end
        end
        S_F0: state <= S_F1;
        S_F1: begin
          dv <= rd_d;
          rv <= rd_r;
          state <= S_F2;
        end
        S_F2: begin
          lv <= mres;
          uv <= a_u.val;
          if (first) begin
            den <= dv;
            state <= S_F4;
          end else begin
            state <= S_F3;
          end
        end
        S_F3: begin
          den <= a_den.val;
          state <= S_F4;
        end
        S_F4: state <= S_F5;
        S_F5: begin
          if (div_done) begin
            cur_eu <= div_q;
            state <= S_F6;
          end
        end
        S_F6: state <= S_F7;
        S_F7: begin
          if (div_done) begin
            cur_ec <= div_q;
            state <= S_F8;
          end
        end
        S_F8: state <= S_F9;
        S_F9: begin
          if (div_done) begin
            p_eu <= cur_eu;
            p_ec <= cur_ec;
            p_eo <= div_q;
            first <= 1'b0;
            if (k == last - AW'(1)) begin
              state <= S_R0;
            end else begin
              k <= k + AW'(1);
              state <= S_F0;
            end
          end
        end
        S_R0: state <= S_R1;
        S_R1: begin
          pv <= rd_d;
          rv <= rd_r;
          state <= S_R2;
        end
        S_R2: begin
          ll <= mres;
          qv <= a_qv.val;
          k <= AW'(1);
          state <= S_R3;
        end
        S_R3: state <= S_R4;
        S_R4: begin
          e_u <= rd_eu;
          e_o <= rd_eo;
          state <= S_R5;
        end
        S_R5: begin
          pv <= a_pv.val;
          state <= S_R6;
        end
        S_R6: begin
          rv <= a_rv.val;
          state <= S_R7;
        end
        S_R7: begin
          qv <= mres;
          if (k == last - AW'(1)) begin
            state <= S_R8;
          end else begin
            k <= k + AW'(1);
            state <= S_R3;
          end
        end
        S_R8: begin
          tv <= a_t.val;
          sv <= a_s.val;
          state <= S_R9;
        end
        S_R9: state <= S_R10;
        S_R10: begin
          den <= a_den2.val;
          state <= S_R11;
        end
        S_R11: state <= S_R12;
        S_R12: begin
          if (div_done) begin
            xl <= div_q;
            xn <= div_q;
            k <= last - AW'(1);
            state <= S_B0;
          end
        end
        S_B0: state <= S_B1;
        S_B1: begin
          e_c <= rd_ec;
          e_o <= rd_eo;
          state <= S_B2;
        end
        S_B2: begin
          acc <= mres;
          state <= S_B3;
        end
        S_B3: begin
          acc <= a_acc.val;
          state <= S_B4;
        end
        S_B4: begin
          xn <= a_x.val;
          if (k == '0) begin
            state <= S_O0;
          end else begin
            k <= k - AW'(1);
            state <= S_B0;
          end
        end
        S_O0: begin
          if (short_run) status <= STATUS_SHORT;
          else if (flag_zero) status <= STATUS_ZERO_PIVOT;
          else if (flag_sat) status <= STATUS_SATURATED;
          else status <= STATUS_OK;
          k <= '0;
          state <= S_O1;
        end
        S_O1: state <= S_O2;
        S_O2: begin
          result_valid <= 1'b1;
          result.solution_value <= short_run ? '0 : rd_sol;
          result.row_index <= IDX_W'(k);
          result.last_result <= k == last;
          result.status <= status;
          if (k == last) begin
            state <= S_IDLE;
          end else begin
            k <= k + AW'(1);
            state <= S_O1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last_result |-> !busy)
    else $error("busy after final result");

  a_start_on_last: assert property (@(posedge clk) disable iff (rst)
    accept && request.last_row |=> busy)
    else $error("solve did not start after final row");

  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == STATUS_SHORT |-> result.solution_value == '0)
    else $error("short run gave nonzero solution");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_run |-> state == S_F5 || state == S_F7 || state == S_F9 || state == S_R12)
    else $error("divider running outside a wait state");
`endif

endmodule

// ----- test/tb.sv -----
// testbench for the cyclic tridiagonal solver: directed and random systems against a predictor
`timescale 1ns / 1ps

module tb import cts_pkg::*; ;

  localparam int ROWS = 64;
  localparam longint LIMIT = 1000000;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  localparam longint ONE = 64'sd65536;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  request_t req = '0;
  logic result_valid;
  result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_WIDTH-1:0] pwdata = '0;
  logic [DATA_WIDTH-1:0] prdata;
  logic pready;

  cyclic_tridiagonal_solver u_top (.request(req), .*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // solver image
  longint diag_m[ROWS], coup_m[ROWS], rhs_m[ROWS];
  longint up_m[ROWS], corner_m[ROWS], offs_m[ROWS], sol_m[ROWS];
  int loaded;
  longint scale = ONE;
  bit sat_seen, zero_seen;

  result_t solution_q[$];
  int errors = 0;
  int rows_sent = 0;
  int systems = 0;
  int checked = 0;
  int status_seen[4];
  longint cycles = 0;
  bit calm = 1'b0;

  function automatic longint clip(longint v);
    if (v > Q_MAX) begin
      sat_seen = 1'b1;
      return Q_MAX;
    end
    if (v < Q_MIN) begin
      sat_seen = 1'b1;
      return Q_MIN;
    end
    return v;
  endfunction

  function automatic longint qadd(longint a, longint b);
    return clip(a + b);
  endfunction

  function automatic longint qsub(longint a, longint b);
    return clip(a - b);
  endfunction

  function automatic longint qmul(longint a, longint b);
    return clip((a * b) / ONE);
  endfunction

  function automatic longint qdiv(longint a, longint b);
    if (b == 0) begin
      zero_seen = 1'b1;
      return 0;
    end
    return clip((a * ONE) / b);
  endfunction

  function automatic longint upper_at(int k);
    return qsub(0, qmul(scale, coup_m[k]));
  endfunction

  function automatic longint lower_at(int k);
    return qmul(scale, coup_m[k]);
  endfunction

  function automatic void eliminate(int n);
    int last;
    longint c, den, pv, qv, rv, pn, rn, t, num, xl;
    last = n - 1;
    up_m[0] = qdiv(upper_at(0), diag_m[0]);
    corner_m[0] = qdiv(lower_at(0), diag_m[0]);
    offs_m[0] = qdiv(rhs_m[0], diag_m[0]);
    for (int k = 1; k < last; k++) begin
      c = lower_at(k);
      den = qsub(diag_m[k], qmul(c, up_m[k-1]));
      up_m[k] = qdiv(upper_at(k), den);
      corner_m[k] = qdiv(qmul(c, corner_m[k-1]), den);
      offs_m[k] = qdiv(qadd(rhs_m[k], qmul(c, offs_m[k-1])), den);
    end
    pv = diag_m[last];
    qv = upper_at(last);
    rv = rhs_m[last];
    for (int k = 1; k < last; k++) begin
      pn = qsub(pv, qmul(qv, corner_m[k-1]));
      rn = qadd(rv, qmul(qv, offs_m[k-1]));
      qv = qmul(qv, up_m[k-1]);
      pv = pn;
      rv = rn;
    end
    t = qadd(qv, lower_at(last));
    den = qsub(pv, qmul(t, qadd(up_m[last-1], corner_m[last-1])));
    num = qadd(rv, qmul(t, offs_m[last-1]));
    xl = qdiv(num, den);
    sol_m[last] = xl;
    for (int k = last - 1; k >= 0; k--)
      sol_m[k] = qadd(qadd(qmul(up_m[k], sol_m[k+1]), qmul(corner_m[k], xl)), offs_m[k]);
  endfunction

  function automatic void take_row(request_t r);
    int n;
    logic [1:0] st;
    result_t res;
    diag_m[loaded] = longint'(r.diag_coeff);
    coup_m[loaded] = longint'(r.coupling_coeff);
    rhs_m[loaded] = longint'(r.rhs_value);
    loaded++;
    if (!r.last_row && loaded < ROWS) return;
    n = loaded;
    loaded = 0;
    sat_seen = 1'b0;
    zero_seen = 1'b0;
    systems++;
    if (n < 3) begin
      for (int k = 0; k < n; k++) sol_m[k] = 0;
      st = STATUS_SHORT;
    end else begin
      eliminate(n);
      st = zero_seen ? STATUS_ZERO_PIVOT : (sat_seen ? STATUS_SATURATED : STATUS_OK);
    end
    for (int k = 0; k < n; k++) begin
      res.solution_value = sol_m[k][31:0];
      res.row_index = k[IDX_W-1:0];
      res.last_result = (k == n - 1);
      res.status = st;
      solution_q.push_back(res);
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout at %0t, %0d solutions outstanding", $time, solution_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
    if (!rst && result_valid) begin
      if (solution_q.size() == 0) begin
        $display("%0t: unexpected solution %h", $time, result);
        errors++;
      end else begin
        want = solution_q.pop_front();
        checked++;
        status_seen[result.status]++;
        if (result.solution_value !== want.solution_value) begin
          $display("%0t: row %0d value expected %h got %h", $time, want.row_index,
                   want.solution_value, result.solution_value);
          errors++;
        end
        if (result.row_index !== want.row_index) begin
          $display("%0t: row_index expected %0d got %0d", $time, want.row_index,
                   result.row_index);
          errors++;
        end
        if (result.last_result !== want.last_result) begin
          $display("%0t: row %0d last_result expected %b got %b", $time, want.row_index,
                   want.last_result, result.last_result);
          errors++;
        end
        if (result.status !== want.status) begin
          $display("%0t: row %0d status expected %0d got %0d", $time, want.row_index,
                   want.status, result.status);
          errors++;
        end
      end
    end
  end

  task automatic send_row(logic [31:0] d, logic [31:0] c, logic [31:0] r, logic lr);
    request_t item;
    @(negedge clk);
    if (!calm && $urandom_range(99) < 13) begin
      start = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    item.diag_coeff = d;
    item.coupling_coeff = c;
    item.rhs_value = r;
    item.last_row = lr;
    req = item;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    take_row(item);
    rows_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (solution_q.size() != 0) @(posedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_scale(logic [31:0] v);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = ADDR_HALF_INV_DX;
    pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    scale = longint'($signed(v));
  endtask

  function automatic logic [31:0] any_word();
    return $urandom();
  endfunction

  // diagonally dominant rows give clean solves
  function automatic logic [31:0] tame_diag();
    logic [31:0] v;
    v = ($urandom_range(2, 8) << 16) | $urandom_range(0, 65535);
    return $urandom_range(1) ? v : -v;
  endfunction

  function automatic logic [31:0] tame_coup();
    logic [31:0] v;
    v = $urandom_range(0, 32768);
    return $urandom_range(1) ? v : -v;
  endfunction

  function automatic logic [31:0] tame_rhs();
    return $signed($urandom_range(0, 200 << 16)) - (100 << 16);
  endfunction

  function automatic logic [31:0] drain_then_value();
    return $urandom_range(1) ? 32'h0001_0000 : any_word();
  endfunction

  task automatic send_system(int n, bit tame);
    for (int k = 0; k < n; k++) begin
      if (tame)
        send_row(tame_diag(), tame_coup(), tame_rhs(), k == n - 1);
      else
        send_row(any_word(), any_word(), any_word(), k == n - 1);
    end
  endtask

  task automatic test_short_systems();
    send_row(32'h0002_0000, 32'h0000_4000, 32'h0001_0000, 1'b1);
    send_row(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
    send_row(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b1);
    drain();
  endtask

  task automatic test_directed_solves();
    send_row(32'h0004_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
    send_row(32'h0004_0000, 32'hffff_0000, 32'h0002_0000, 1'b0);
    send_row(32'h0004_0000, 32'h0000_8000, 32'hfffd_0000, 1'b1);
    // zero pivot on the first row
    send_row(32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
    send_row(32'h0003_0000, 32'h0000_0000, 32'h0001_0000, 1'b0);
    send_row(32'h0003_0000, 32'h0000_0000, 32'h0001_0000, 1'b1);
    // saturating extremes
    send_row(32'h0000_0001, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    send_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_row(32'h7fff_ffff, 32'hffff_ffff, 32'h0000_0000, 1'b0);
    send_row(32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff, 1'b1);
    drain();
  endtask

  task automatic test_scale_settings();
    logic [31:0] settings[5];
    settings = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_8000, 32'h0000_8000};
    foreach (settings[i]) begin
      write_scale(settings[i]);
      send_system(3 + i, i > 2);
      drain();
    end
    write_scale(32'h0001_0000);
  endtask

  task automatic test_full_store();
    for (int k = 0; k < ROWS; k++)
      send_row(tame_diag(), tame_coup(), tame_rhs(), 1'b0);
    drain();
  endtask

  task automatic test_random_systems();
    int pick;
    calm = 1'b1;
    repeat (6) send_system($urandom_range(3, 6), 1'b1);
    calm = 1'b0;
    while (rows_sent < 350) begin
      pick = $urandom_range(99);
      if (pick < 60) send_system($urandom_range(3, 8), 1'b1);
      else if (pick < 80) send_system($urandom_range(3, 6), 1'b0);
      else if (pick < 92) send_system($urandom_range(1, 2), 1'($urandom_range(1)));
      else if (pick < 97) begin
        drain();
        write_scale(drain_then_value());
        send_system($urandom_range(3, 10), 1'($urandom_range(1)));
      end else send_system($urandom_range(12, 20), 1'b1);
    end
    drain();
  endtask

  initial begin
    loaded = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_short_systems();
    test_directed_solves();
    test_scale_settings();
    test_full_store();
    test_random_systems();
    repeat (50) @(posedge clk);
    $display("%0d rows in %0d systems, %0d solutions checked", rows_sent, systems, checked);
    $display("status ok %0d, zero pivot %0d, short %0d, saturated %0d", status_seen[0],
             status_seen[1], status_seen[2], status_seen[3]);
    if (errors == 0 && solution_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
